@@ src/crps_pkg.sv @@
// Shared types and constants for the circle ring pixel shader.
// Used by the interfaces, the pipeline modules and the top level.
package crps_pkg;

  localparam int COORD_BITS_DEFAULT = 14;

  localparam int PIX_W      = 13;
  localparam int LEN_W      = 13;
  localparam int COLOR_W    = 32;
  localparam int REGION_W   = 2;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;

  // Ring bounds: inner fits the radius width, outer needs one more bit.
  localparam int BOUND_W = LEN_W + 1;
  localparam int IN2_W   = 2 * LEN_W;
  localparam int OUT2_W  = 2 * BOUND_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CTR_COL           = 3'd0,
    REG_CTR_ROW           = 3'd1,
    REG_CIRCLE_RADIUS     = 3'd2,
    REG_OUTLINE_THICKNESS = 3'd3,
    REG_FILL_ENABLE       = 3'd4,
    REG_OUTLINE_COLOR     = 3'd5,
    REG_INTERIOR_COLOR    = 3'd6
  } cfg_reg_t;

  typedef enum logic [REGION_W-1:0] {
    REGION_NONE     = 2'd0,
    REGION_OUTLINE  = 2'd1,
    REGION_INTERIOR = 2'd2
  } region_t;

  // Configuration of fixed width; the center coordinates travel separately
  // because their width follows COORD_BITS.
  typedef struct packed {
    logic [LEN_W-1:0]   circle_radius;
    logic [LEN_W-1:0]   outline_thickness;
    logic               fill_enable;
    logic [COLOR_W-1:0] outline_color;
    logic [COLOR_W-1:0] interior_color;
  } shade_cfg_t;

endpackage

@@ src/crps_pix_if.sv @@
// Pixel input channel: valid/ready handshake with coordinates and color.
// Depends on crps_pkg for field widths.
interface crps_pix_if
  import crps_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [PIX_W-1:0]   pixel_col;
  logic [PIX_W-1:0]   pixel_row;
  logic [COLOR_W-1:0] pixel_rgba;

  modport source (output valid, output pixel_col, output pixel_row, output pixel_rgba,
                  input ready);
  modport sink   (input valid, input pixel_col, input pixel_row, input pixel_rgba,
                  output ready);
endinterface

@@ src/crps_res_if.sv @@
// Result channel: valid/ready handshake with the shaded color and region code.
// Depends on crps_pkg for field widths.
interface crps_res_if
  import crps_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [COLOR_W-1:0]  out_rgba;
  logic [REGION_W-1:0] region;

  modport source (output valid, output out_rgba, output region, input ready);
  modport sink   (input valid, input out_rgba, input region, output ready);
endinterface

@@ src/crps_cfg_regs.sv @@
// Configuration register file written through a plain indexed write port.
// Depends on crps_pkg.
module crps_cfg_regs
  import crps_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  output logic signed [COORD_BITS-1:0] ctr_col,
  output logic signed [COORD_BITS-1:0] ctr_row,
  output shade_cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctr_col <= '0;
      ctr_row <= '0;
      cfg     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CTR_COL:           ctr_col <= signed'(cfg_data[COORD_BITS-1:0]);
        REG_CTR_ROW:           ctr_row <= signed'(cfg_data[COORD_BITS-1:0]);
        REG_CIRCLE_RADIUS:     cfg.circle_radius <= cfg_data[LEN_W-1:0];
        REG_OUTLINE_THICKNESS: cfg.outline_thickness <= cfg_data[LEN_W-1:0];
        REG_FILL_ENABLE:       cfg.fill_enable <= cfg_data[0];
        REG_OUTLINE_COLOR:     cfg.outline_color <= cfg_data[COLOR_W-1:0];
        REG_INTERIOR_COLOR:    cfg.interior_color <= cfg_data[COLOR_W-1:0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

endmodule

@@ src/crps_dist.sv @@
// First three pipeline stages: offsets, squares, squared distance; the ring
// bounds and their squares run alongside. Depends on crps_pkg.
module crps_dist
  import crps_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEFAULT,
  localparam int DX_W = ((COORD_BITS > 14) ? COORD_BITS : 14) + 1,
  localparam int MAG_W = DX_W - 1,
  localparam int SQ_W = 2 * MAG_W,
  localparam int D2_W = SQ_W + 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [PIX_W-1:0]             pixel_col,
  input  logic [PIX_W-1:0]             pixel_row,
  input  logic [COLOR_W-1:0]           pixel_rgba,
  input  logic signed [COORD_BITS-1:0] ctr_col,
  input  logic signed [COORD_BITS-1:0] ctr_row,
  input  shade_cfg_t                   cfg,
  output logic                         d_valid,
  output logic [D2_W-1:0]              d2,
  output logic [IN2_W-1:0]             in2,
  output logic [OUT2_W-1:0]            out2,
  output logic [COLOR_W-1:0]           d_rgba
);

  logic signed [DX_W-1:0] col_s, row_s, cx_s, cy_s, dx, dy;
  logic [LEN_W-2:0]       half;
  logic [LEN_W-1:0]       inner_next;
  logic [BOUND_W-1:0]     outer_next;

  // Stage 1 registers
  logic               v1;
  logic [MAG_W-1:0]   mag_x, mag_y;
  logic [LEN_W-1:0]   inner;
  logic [BOUND_W-1:0] outer;
  logic [COLOR_W-1:0] rgba1;
  // Stage 2 registers
  logic               v2;
  logic [SQ_W-1:0]    dx2, dy2;
  logic [IN2_W-1:0]   in2_s2;
  logic [OUT2_W-1:0]  out2_s2;
  logic [COLOR_W-1:0] rgba2;

  always_comb begin
    col_s = DX_W'(signed'({1'b0, pixel_col}));
    row_s = DX_W'(signed'({1'b0, pixel_row}));
    cx_s  = DX_W'(ctr_col);
    cy_s  = DX_W'(ctr_row);
    dx    = col_s - cx_s;
    dy    = row_s - cy_s;
    half  = cfg.outline_thickness[LEN_W-1:1];
    outer_next = BOUND_W'(cfg.circle_radius) + BOUND_W'(half);
    // Saturate the inner bound at zero
    if (cfg.circle_radius > LEN_W'(half)) begin
      inner_next = cfg.circle_radius - LEN_W'(half);
    end else begin
      inner_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1      <= 1'b0;
      v2      <= 1'b0;
      d_valid <= 1'b0;
    end else if (en) begin
      v1      <= in_valid;
      v2      <= v1;
      d_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_x   <= dx[DX_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
      mag_y   <= dy[DX_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
      inner   <= inner_next;
      outer   <= outer_next;
      rgba1   <= pixel_rgba;

      dx2     <= SQ_W'(mag_x) * SQ_W'(mag_x);
      dy2     <= SQ_W'(mag_y) * SQ_W'(mag_y);
      in2_s2  <= IN2_W'(inner) * IN2_W'(inner);
      out2_s2 <= OUT2_W'(outer) * OUT2_W'(outer);
      rgba2   <= rgba1;

      d2      <= D2_W'(dx2) + D2_W'(dy2);
      in2     <= in2_s2;
      out2    <= out2_s2;
      d_rgba  <= rgba2;
    end
  end

endmodule

@@ src/crps_shade.sv @@
// Last pipeline stage: ring and interior tests, color select, output register.
// Depends on crps_pkg.
module crps_shade
  import crps_pkg::*;
#(
  parameter int D2_W = 29
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [D2_W-1:0]     d2,
  input  logic [IN2_W-1:0]    in2,
  input  logic [OUT2_W-1:0]   out2,
  input  logic [COLOR_W-1:0]  rgba,
  input  shade_cfg_t          cfg,
  output logic                res_valid,
  output logic [COLOR_W-1:0]  out_rgba,
  output logic [REGION_W-1:0] region
);

  logic               above_inner, below_inner, below_outer;
  logic [COLOR_W-1:0] rgba_next;
  region_t            region_next;

  always_comb begin
    above_inner = d2 > D2_W'(in2);
    below_inner = d2 < D2_W'(in2);
    below_outer = d2 < D2_W'(out2);
    // Exactly on either boundary leaves the pixel alone
    priority if (above_inner && below_outer) begin
      rgba_next   = cfg.outline_color;
      region_next = REGION_OUTLINE;
    end else if (cfg.fill_enable && below_inner) begin
      rgba_next   = cfg.interior_color;
      region_next = REGION_INTERIOR;
    end else begin
      rgba_next   = rgba;
      region_next = REGION_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rgba <= rgba_next;
      region   <= region_next;
    end
  end

endmodule

@@ src/circle_ring_pixel_shader.sv @@
// Circle ring pixel shader: recolors a pixel stream with a thick circle
// outline and optional fill. Depends on crps_pkg, crps_pix_if, crps_res_if,
// crps_cfg_regs, crps_dist and crps_shade.
//
// Usage:
//   pixel  - input channel (valid/ready): column, row and RGBA color.
//   result - output channel (valid/ready): new RGBA color and region code
//            (none, outline ring, interior fill), one result per pixel.
//   cfg_*  - register writes, one per cycle when cfg_we is high; write only
//            while no pixel is in flight.
// Timing:
//   Four register stages (offsets, squares, distance sum, classify). The
//   first stage loads at the pixel transfer; the result passes the
//   squares, distance sum and classify registers and transfers when
//   the receiver takes it. One pixel per clock is sustained while it
//   keeps ready high; the squaring stage's four multipliers set the stage depth.
// Reset clears every configuration register to zero and empties the pipeline.
// Stall: when the output holds a result that is not taken, the whole
// pipeline holds and pixel.ready drops; nothing is lost or repeated.
module circle_ring_pixel_shader
  import crps_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  crps_pix_if.sink              pixel,
  crps_res_if.source            result
);

  localparam int DX_W  = ((COORD_BITS > 14) ? COORD_BITS : 14) + 1;
  localparam int D2_W  = 2 * (DX_W - 1) + 1;

  logic signed [COORD_BITS-1:0] ctr_col, ctr_row;
  shade_cfg_t                   cfg;
  logic                         en;
  logic                         d_valid;
  logic [D2_W-1:0]              d2;
  logic [IN2_W-1:0]             in2;
  logic [OUT2_W-1:0]            out2;
  logic [COLOR_W-1:0]           d_rgba;

  // Advance whenever the output register is empty or being taken
  assign en          = !result.valid || result.ready;
  assign pixel.ready = en;

  crps_cfg_regs #(.COORD_BITS(COORD_BITS)) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .ctr_col  (ctr_col),
    .ctr_row  (ctr_row),
    .cfg      (cfg)
  );

  crps_dist #(.COORD_BITS(COORD_BITS)) u_dist (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (pixel.valid),
    .pixel_col (pixel.pixel_col),
    .pixel_row (pixel.pixel_row),
    .pixel_rgba(pixel.pixel_rgba),
    .ctr_col   (ctr_col),
    .ctr_row   (ctr_row),
    .cfg       (cfg),
    .d_valid   (d_valid),
    .d2        (d2),
    .in2       (in2),
    .out2      (out2),
    .d_rgba    (d_rgba)
  );

  crps_shade #(.D2_W(D2_W)) u_shade (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (d_valid),
    .d2       (d2),
    .in2      (in2),
    .out2     (out2),
    .rgba     (d_rgba),
    .cfg      (cfg),
    .res_valid(result.valid),
    .out_rgba (result.out_rgba),
    .region   (result.region)
  );

endmodule

@@ src/crps_checker.sv @@
// Port-level checks for the circle ring pixel shader, bound to the top level.
// Depends on crps_pkg.
module crps_checker
  import crps_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                in_ready,
  input logic                res_valid,
  input logic                res_ready,
  input logic [COLOR_W-1:0]  out_rgba,
  input logic [REGION_W-1:0] region
);

  // Reset empties the output stage
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  // An empty output stage never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) !res_valid |-> in_ready)
    else $error("input stalled with empty output");

  // Input stalls only when the result is held
  a_stall_cause: assert property (@(posedge clk)
      !in_ready |-> (res_valid && !res_ready))
    else $error("input stalled without output backpressure");

  // A held result keeps its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
      (res_valid && !res_ready) |=> (res_valid && $stable(out_rgba) && $stable(region)))
    else $error("stalled result changed");

  a_region_code: assert property (@(posedge clk) disable iff (rst)
      res_valid |-> (region == REGION_NONE || region == REGION_OUTLINE ||
                     region == REGION_INTERIOR))
    else $error("undefined region code");

endmodule

bind circle_ring_pixel_shader crps_checker u_crps_checker (
  .clk      (clk),
  .rst      (rst),
  .in_ready (pixel.ready),
  .res_valid(result.valid),
  .res_ready(result.ready),
  .out_rgba (result.out_rgba),
  .region   (result.region)
);
